[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, with checking held off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, with checking held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/mcdp_pkg.sv]
// ----------------------------------------------------------------------------
// mcdp_pkg
// Types and constants for the composition data page 0 parser.
// ----------------------------------------------------------------------------
package mcdp_pkg;

    // Node address space that has count tables; models past this are dropped.
    localparam int NODE_COUNT  = 32;
    localparam int MAX_MODELS  = 8;

    // Result queue depth. An input beat can produce two results.
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    localparam logic [2:0] KIND_HEADER = 3'd0;
    localparam logic [2:0] KIND_ELEM   = 3'd1;
    localparam logic [2:0] KIND_SIG    = 3'd2;
    localparam logic [2:0] KIND_VENDOR = 3'd3;
    localparam logic [2:0] KIND_END    = 3'd4;

    typedef struct packed {
        logic [15:0] device_addr;
        logic [7:0]  data_byte;
        logic        last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [15:0] node_addr;
        logic [2:0]  slot_index;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [15:0] word_c;
        logic [15:0] word_d;
        logic [15:0] word_e;
        logic [3:0]  sig_total;
        logic [3:0]  vendor_total;
        logic        dropped;
        logic        final_result;
    } out_beat_t;

endpackage

[rtl/mesh_composition_data_parser.sv]
// ----------------------------------------------------------------------------
// mesh_composition_data_parser
// Composition data page 0 parser: header, elements, SIG and vendor models.
// ----------------------------------------------------------------------------
// Takes one byte of composition data per cycle. Each byte is parsed at the
// edge it is accepted, and its results (one at most, two on a final byte that
// also closes a record: the record and then the end-of-data record) go into a
// four-entry result queue that drains one result per cycle while out_ready is
// high. in_ready drops only while fewer than two queue slots are free, so a
// consumer that takes a result every cycle sees a sustained rate of one byte
// per cycle; a final byte that yields two results leaves the consumer one
// more result to take. Model counts are kept for the node being parsed and
// are cleared at its first header byte; nodes at or above NODE_COUNT store
// nothing and report zero totals.
module mesh_composition_data_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mcdp_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mcdp_pkg::out_beat_t out_data
);
    import mcdp_pkg::*;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_ELEM   = 2'd1;
    localparam logic [1:0] PH_SIG    = 2'd2;
    localparam logic [1:0] PH_VEN    = 2'd3;

    // Parser state
    logic [1:0]  phase_reg,   phase_next;
    logic [3:0]  pos_reg,     pos_next;
    logic [7:0]  sig_rem_reg, sig_rem_next;
    logic [7:0]  ven_rem_reg, ven_rem_next;
    logic [7:0]  low_reg,     low_next;
    logic [15:0] hw_reg [4];
    logic [15:0] hw_next [4];
    logic [15:0] node_reg,    node_next;
    logic [3:0]  sig_cnt_reg, sig_cnt_next;
    logic [3:0]  ven_cnt_reg, ven_cnt_next;

    // Result queue
    out_beat_t            fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   cnt_reg,    cnt_next;

    logic        in_fire;
    logic        out_fire;
    logic        start;
    logic        node_ok;
    logic [15:0] word;
    logic [3:0]  sig_base;
    logic [3:0]  ven_base;
    logic        main_valid;
    logic [2:0]  m_kind;
    logic [2:0]  m_slot;
    logic [15:0] m_a, m_b, m_c, m_d, m_e;
    logic        m_drop;
    logic        clean;
    logic [3:0]  sig_tot;
    logic [3:0]  ven_tot;
    out_beat_t   rec0;
    out_beat_t   rec1;
    logic [1:0]  push_n;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready = cnt_reg <= FIFO_CW'(FIFO_DEPTH - 2);
    assign out_valid = cnt_reg != '0;
    assign out_data  = fifo_reg[rd_ptr_reg];

    assign start    = (phase_reg == PH_HEADER) && (pos_reg == 4'd0);
    assign node_next = start ? in_data.device_addr : node_reg;
    assign node_ok  = node_next < 16'(NODE_COUNT);
    assign word     = {in_data.data_byte, low_reg};
    assign sig_base = start ? 4'd0 : sig_cnt_reg;
    assign ven_base = start ? 4'd0 : ven_cnt_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        sig_rem_next = sig_rem_reg;
        ven_rem_next = ven_rem_reg;
        low_next     = low_reg;
        hw_next      = hw_reg;
        sig_cnt_next = sig_base;
        ven_cnt_next = ven_base;
        main_valid   = 1'b0;
        m_kind       = KIND_HEADER;
        m_slot       = 3'd0;
        m_a          = 16'd0;
        m_b          = 16'd0;
        m_c          = 16'd0;
        m_d          = 16'd0;
        m_e          = 16'd0;
        m_drop       = 1'b0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (!pos_reg[0])
                begin
                    low_next = in_data.data_byte;
                    pos_next = pos_reg + 4'd1;
                end
                else if (pos_reg < 4'd9)
                begin
                    hw_next[pos_reg[2:1]] = word;
                    pos_next = pos_reg + 4'd1;
                end
                else
                begin
                    main_valid = 1'b1;
                    m_kind     = KIND_HEADER;
                    m_a        = hw_reg[0];
                    m_b        = hw_reg[1];
                    m_c        = hw_reg[2];
                    m_d        = hw_reg[3];
                    m_e        = word;
                    phase_next = PH_ELEM;
                    pos_next   = 4'd0;
                end
            end
            PH_ELEM:
            begin
                case (pos_reg)
                    4'd0:
                    begin
                        low_next = in_data.data_byte;
                        pos_next = 4'd1;
                    end
                    4'd1:
                    begin
                        hw_next[0] = word;
                        pos_next   = 4'd2;
                    end
                    4'd2:
                    begin
                        hw_next[1] = {8'd0, in_data.data_byte};
                        pos_next   = 4'd3;
                    end
                    default:
                    begin
                        main_valid   = 1'b1;
                        m_kind       = KIND_ELEM;
                        m_a          = hw_reg[0];
                        m_b          = hw_reg[1];
                        m_c          = {8'd0, in_data.data_byte};
                        sig_rem_next = hw_reg[1][7:0];
                        ven_rem_next = in_data.data_byte;
                        pos_next     = 4'd0;
                        if (hw_reg[1][7:0] != 8'd0)
                            phase_next = PH_SIG;
                        else if (in_data.data_byte != 8'd0)
                            phase_next = PH_VEN;
                        else
                            phase_next = PH_ELEM;
                    end
                endcase
            end
            PH_SIG:
            begin
                if (pos_reg == 4'd0)
                begin
                    low_next = in_data.data_byte;
                    pos_next = 4'd1;
                end
                else
                begin
                    main_valid = 1'b1;
                    m_kind     = KIND_SIG;
                    m_a        = word;
                    m_drop     = 1'b1;
                    if (node_ok && (sig_base < 4'(MAX_MODELS)))
                    begin
                        m_slot       = sig_base[2:0];
                        sig_cnt_next = sig_base + 4'd1;
                        m_drop       = 1'b0;
                    end
                    sig_rem_next = sig_rem_reg - 8'd1;
                    pos_next     = 4'd0;
                    if (sig_rem_reg == 8'd1)
                        phase_next = (ven_rem_reg != 8'd0) ? PH_VEN : PH_ELEM;
                end
            end
            default:
            begin
                if (pos_reg == 4'd0 || pos_reg == 4'd2)
                begin
                    low_next = in_data.data_byte;
                    pos_next = pos_reg + 4'd1;
                end
                else if (pos_reg == 4'd1)
                begin
                    hw_next[0] = word;
                    pos_next   = 4'd2;
                end
                else
                begin
                    main_valid = 1'b1;
                    m_kind     = KIND_VENDOR;
                    m_a        = word;
                    m_b        = hw_reg[0];
                    m_drop     = 1'b1;
                    if (node_ok && (ven_base < 4'(MAX_MODELS)))
                    begin
                        m_slot       = ven_base[2:0];
                        ven_cnt_next = ven_base + 4'd1;
                        m_drop       = 1'b0;
                    end
                    ven_rem_next = ven_rem_reg - 8'd1;
                    pos_next     = 4'd0;
                    if (ven_rem_reg == 8'd1)
                        phase_next = PH_ELEM;
                end
            end
        endcase

        // Clean end only on an element boundary after a complete header.
        clean = (phase_next == PH_ELEM) && (pos_next == 4'd0);
        if (in_data.last_byte)
        begin
            phase_next   = PH_HEADER;
            pos_next     = 4'd0;
            sig_rem_next = 8'd0;
            ven_rem_next = 8'd0;
        end
    end

    assign sig_tot = node_ok ? sig_cnt_next : 4'd0;
    assign ven_tot = node_ok ? ven_cnt_next : 4'd0;

    always_comb
    begin
        rec1.record_kind  = KIND_END;
        rec1.node_addr    = node_next;
        rec1.slot_index   = 3'd0;
        rec1.word_a       = 16'd0;
        rec1.word_b       = 16'd0;
        rec1.word_c       = 16'd0;
        rec1.word_d       = 16'd0;
        rec1.word_e       = 16'd0;
        rec1.sig_total    = sig_tot;
        rec1.vendor_total = ven_tot;
        rec1.dropped      = !clean;
        rec1.final_result = 1'b1;

        if (main_valid)
        begin
            rec0.record_kind  = m_kind;
            rec0.node_addr    = node_next;
            rec0.slot_index   = m_slot;
            rec0.word_a       = m_a;
            rec0.word_b       = m_b;
            rec0.word_c       = m_c;
            rec0.word_d       = m_d;
            rec0.word_e       = m_e;
            rec0.sig_total    = sig_tot;
            rec0.vendor_total = ven_tot;
            rec0.dropped      = m_drop;
            rec0.final_result = !in_data.last_byte;
        end
        else
        begin
            rec0 = rec1;
        end

        push_n = 2'(main_valid) + 2'(in_data.last_byte);
        if (!in_fire)
            push_n = 2'd0;
    end

    assign wr_ptr_next = wr_ptr_reg + FIFO_AW'(push_n);
    assign rd_ptr_next = rd_ptr_reg + FIFO_AW'(out_fire);
    assign cnt_next    = cnt_reg + FIFO_CW'(push_n) - FIFO_CW'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            pos_reg     <= 4'd0;
            sig_rem_reg <= 8'd0;
            ven_rem_reg <= 8'd0;
            low_reg     <= 8'd0;
            hw_reg      <= '{default: 16'd0};
            node_reg    <= 16'd0;
            sig_cnt_reg <= 4'd0;
            ven_cnt_reg <= 4'd0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                sig_rem_reg <= sig_rem_next;
                ven_rem_reg <= ven_rem_next;
                low_reg     <= low_next;
                hw_reg      <= hw_next;
                node_reg    <= node_next;
                sig_cnt_reg <= sig_cnt_next;
                ven_cnt_reg <= ven_cnt_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_reg[wr_ptr_reg] <= rec0;
        if (push_n == 2'd2)
            fifo_reg[wr_ptr_reg + FIFO_AW'(1)] <= rec1;
    end

endmodule

[rtl/mcdp_checker.sv]
// ----------------------------------------------------------------------------
// mcdp_checker
// Port-level checks for the composition data parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcdp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input mcdp_pkg::in_beat_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input mcdp_pkg::out_beat_t out_data
);
    import mcdp_pkg::*;

    logic last_in;
    logic end_out;
    logic model_drop;

    assign last_in    = in_valid && in_ready && in_data.last_byte;
    assign end_out    = out_valid && (out_data.record_kind == KIND_END);
    assign model_drop = out_valid && out_data.dropped &&
                        (out_data.record_kind == KIND_SIG ||
                         out_data.record_kind == KIND_VENDOR);

    // A final beat always leaves at least the end record queued.
    `ASSERT_NEXT(a_last_gives_result, clk, rst_n, last_in, out_valid)

    // End record closes the results of its beat.
    `ASSERT_IMPLY(a_end_is_final, clk, rst_n, end_out, out_data.final_result)

    // Dropped models never claim a table slot.
    `ASSERT_IMPLY(a_drop_slot_zero, clk, rst_n, model_drop, out_data.slot_index == 3'd0)

    // Stalled result holds.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind mesh_composition_data_parser mcdp_checker u_mcdp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the composition data page 0 parser.
// ----------------------------------------------------------------------------
// Byte streams of whole nodes (header, elements, SIG and vendor models) go in
// with random content, along with streams that are cut short, that announce
// more models than they carry, and plain noise. A predictor written from the
// parser's spec builds the expected records for every accepted byte. A checker
// compares each record taken from the output with the oldest prediction,
// field by field. Both sides idle at random, except for one steady stretch.
// ----------------------------------------------------------------------------
module testbench;
    import mcdp_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDLE_PCT     = 14;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ELEM,
        PH_SIG,
        PH_VEN
    } parse_phase_e;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_beat_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;

    mesh_composition_data_parser DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Parser predictor
    // ------------------------------------------------------------------
    parse_phase_e phase;
    logic [3:0]   pos;
    logic [7:0]   sig_left;
    logic [7:0]   ven_left;
    logic [7:0]   low_hold;
    logic [15:0]  words [4];
    logic [15:0]  node;
    logic [3:0]   sig_cnt [NODE_COUNT];
    logic [3:0]   ven_cnt [NODE_COUNT];

    out_beat_t expected_records [$];

    int items_sent;
    int records_seen;
    int models_dropped;
    int nodes_closed;
    int mismatches;
    logic steady;

    function automatic void reset_predictor();
        phase    = PH_HEADER;
        pos      = '0;
        sig_left = '0;
        ven_left = '0;
        low_hold = '0;
        node     = '0;
        for (int i = 0; i < 4; i++)
            words[i] = '0;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            sig_cnt[i] = '0;
            ven_cnt[i] = '0;
        end
    endfunction

    function automatic logic node_in_range();
        return node < NODE_COUNT;
    endfunction

    function automatic out_beat_t make_record(logic [2:0] kind, logic [2:0] slot,
                                              logic [15:0] a, logic [15:0] b,
                                              logic [15:0] c, logic [15:0] d,
                                              logic [15:0] e, logic drop);
        out_beat_t r;
        r              = '0;
        r.record_kind  = kind;
        r.node_addr    = node;
        r.slot_index   = slot;
        r.word_a       = a;
        r.word_b       = b;
        r.word_c       = c;
        r.word_d       = d;
        r.word_e       = e;
        r.dropped      = drop;
        if (node_in_range())
        begin
            r.sig_total    = sig_cnt[node];
            r.vendor_total = ven_cnt[node];
        end
        return r;
    endfunction

    function automatic void predict_records(in_beat_t b);
        logic [15:0] word;
        logic [2:0]  slot;
        logic        drop;
        logic        clean;
        int          n;
        out_beat_t   tail;

        word = {b.data_byte, low_hold};
        n    = 0;

        // first header byte latches the node and clears its counts
        if (phase == PH_HEADER && pos == 0)
        begin
            node = b.device_addr;
            if (node_in_range())
            begin
                sig_cnt[node] = '0;
                ven_cnt[node] = '0;
            end
        end

        case (phase)
            PH_HEADER:
            begin
                if (!pos[0])
                begin
                    low_hold = b.data_byte;
                    pos      = pos + 4'd1;
                end
                else if (pos < 4'd9)
                begin
                    words[pos[2:1]] = word;
                    pos             = pos + 4'd1;
                end
                else
                begin
                    expected_records.push_back(make_record(KIND_HEADER, '0, words[0],
                        words[1], words[2], words[3], word, 1'b0));
                    n++;
                    phase = PH_ELEM;
                    pos   = '0;
                end
            end
            PH_ELEM:
            begin
                if (pos == 0)
                begin
                    low_hold = b.data_byte;
                    pos      = 4'd1;
                end
                else if (pos == 1)
                begin
                    words[0] = word;
                    pos      = 4'd2;
                end
                else if (pos == 2)
                begin
                    words[1] = {8'h00, b.data_byte};
                    pos      = 4'd3;
                end
                else
                begin
                    expected_records.push_back(make_record(KIND_ELEM, '0, words[0],
                        words[1], {8'h00, b.data_byte}, '0, '0, 1'b0));
                    n++;
                    sig_left = words[1][7:0];
                    ven_left = b.data_byte;
                    pos      = '0;
                    if (sig_left != 0)
                        phase = PH_SIG;
                    else if (ven_left != 0)
                        phase = PH_VEN;
                    else
                        phase = PH_ELEM;
                end
            end
            PH_SIG:
            begin
                if (pos == 0)
                begin
                    low_hold = b.data_byte;
                    pos      = 4'd1;
                end
                else
                begin
                    slot = '0;
                    drop = 1'b1;
                    if (node_in_range() && sig_cnt[node] < MAX_MODELS)
                    begin
                        slot          = sig_cnt[node][2:0];
                        sig_cnt[node] = sig_cnt[node] + 4'd1;
                        drop          = 1'b0;
                    end
                    expected_records.push_back(make_record(KIND_SIG, slot, word,
                        '0, '0, '0, '0, drop));
                    n++;
                    sig_left = sig_left - 8'd1;
                    pos      = '0;
                    if (sig_left == 0)
                        phase = (ven_left != 0) ? PH_VEN : PH_ELEM;
                end
            end
            default:
            begin
                if (pos == 0 || pos == 2)
                begin
                    low_hold = b.data_byte;
                    pos      = pos + 4'd1;
                end
                else if (pos == 1)
                begin
                    words[0] = word;
                    pos      = 4'd2;
                end
                else
                begin
                    slot = '0;
                    drop = 1'b1;
                    if (node_in_range() && ven_cnt[node] < MAX_MODELS)
                    begin
                        slot          = ven_cnt[node][2:0];
                        ven_cnt[node] = ven_cnt[node] + 4'd1;
                        drop          = 1'b0;
                    end
                    expected_records.push_back(make_record(KIND_VENDOR, slot, word,
                        words[0], '0, '0, '0, drop));
                    n++;
                    ven_left = ven_left - 8'd1;
                    pos      = '0;
                    if (ven_left == 0)
                        phase = PH_ELEM;
                end
            end
        endcase

        if (b.last_byte)
        begin
            // clean only when the stream stops on an element boundary
            clean = (phase == PH_ELEM && pos == 0);
            expected_records.push_back(make_record(KIND_END, '0, '0, '0, '0, '0, '0,
                !clean));
            n++;
            phase    = PH_HEADER;
            pos      = '0;
            sig_left = '0;
            ven_left = '0;
        end

        if (n > 0)
        begin
            tail              = expected_records.pop_back();
            tail.final_result = 1'b1;
            expected_records.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            note_mismatch($sformatf("record %0d %s: got %h, expected %h",
                                    records_seen, name, got, want));
    endtask

    always @(posedge clk)
    begin : record_checker
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_records.size() == 0)
                note_mismatch($sformatf("record with nothing expected: %h", out_data));
            else
            begin
                want = expected_records.pop_front();
                check_field("record_kind",  16'(out_data.record_kind),
                            16'(want.record_kind));
                check_field("node_addr",    out_data.node_addr,    want.node_addr);
                check_field("slot_index",   16'(out_data.slot_index),
                            16'(want.slot_index));
                check_field("word_a",       out_data.word_a,       want.word_a);
                check_field("word_b",       out_data.word_b,       want.word_b);
                check_field("word_c",       out_data.word_c,       want.word_c);
                check_field("word_d",       out_data.word_d,       want.word_d);
                check_field("word_e",       out_data.word_e,       want.word_e);
                check_field("sig_total",    16'(out_data.sig_total),
                            16'(want.sig_total));
                check_field("vendor_total", 16'(out_data.vendor_total),
                            16'(want.vendor_total));
                check_field("dropped",      16'(out_data.dropped),
                            16'(want.dropped));
                check_field("final_result", 16'(out_data.final_result),
                            16'(want.final_result));
                if (want.dropped)
                    models_dropped++;
                if (want.record_kind == KIND_END)
                    nodes_closed++;
            end
            records_seen++;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Watchdog: too long with no beat on either side
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [15:0] addr, input logic [7:0] data,
                             input logic last);
        in_beat_t beat;
        beat.device_addr = addr;
        beat.data_byte   = data;
        beat.last_byte   = last;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_records(beat);
        items_sent++;
    endtask

    function automatic logic [15:0] pick_node();
        int r;
        r = $urandom_range(9);
        if (r < 7)
            return 16'($urandom_range(NODE_COUNT - 1));
        else if (r < 8)
            return 16'(NODE_COUNT + $urandom_range(3));
        return 16'($urandom);
    endfunction

    // One node's page 0 data, optionally cut after 'cut' bytes. Address
    // noise on later bytes must be ignored.
    task automatic send_node(input logic [15:0] addr, input int elems,
                             input int lo, input int hi, input int cut);
        logic [7:0] bytes [$];
        int         s;
        int         v;
        int         n;
        repeat (10)
            bytes.push_back(8'($urandom));
        repeat (elems)
        begin
            s = $urandom_range(hi, lo);
            v = $urandom_range(hi, lo);
            bytes.push_back(8'($urandom));
            bytes.push_back(8'($urandom));
            bytes.push_back(8'(s));
            bytes.push_back(8'(v));
            repeat (2 * s)
                bytes.push_back(8'($urandom));
            repeat (4 * v)
                bytes.push_back(8'($urandom));
        end
        n = (cut > 0 && cut < bytes.size()) ? cut : bytes.size();
        for (int i = 0; i < n; i++)
            send_byte((i == 0 || $urandom_range(3) != 0) ? addr : 16'($urandom),
                      bytes[i], i == n - 1);
    endtask

    task automatic test_header_extremes();
        logic [15:0] a;
        a = 16'(NODE_COUNT - 1);
        // company FFFF, product 0000, version 00FF, replay FF00, features 5AA5
        send_byte(a, 8'hFF, 1'b0);
        send_byte(a, 8'hFF, 1'b0);
        send_byte(a, 8'h00, 1'b0);
        send_byte(a, 8'h00, 1'b0);
        send_byte(a, 8'hFF, 1'b0);
        send_byte(a, 8'h00, 1'b0);
        send_byte(a, 8'h00, 1'b0);
        send_byte(a, 8'hFF, 1'b0);
        send_byte(a, 8'hA5, 1'b0);
        send_byte(a, 8'h5A, 1'b0);
        // element with no models, data ends right on its boundary
        send_byte(a, 8'h34, 1'b0);
        send_byte(a, 8'h12, 1'b0);
        send_byte(a, 8'h00, 1'b0);
        send_byte(a, 8'h00, 1'b1);
    endtask

    task automatic test_cut_short();
        // last mark on the very first byte, then a header cut in the middle
        send_byte(16'hFFFF, 8'h00, 1'b1);
        send_byte(16'h0000, 8'hFF, 1'b0);
        send_byte(16'hFFFF, 8'h00, 1'b0);
        send_byte(16'h0000, 8'hFF, 1'b0);
        send_byte(16'hFFFF, 8'h00, 1'b0);
        send_byte(16'h0000, 8'hFF, 1'b1);
    endtask

    task automatic test_table_full();
        // more than MAX_MODELS of each kind, in range and out of range
        send_node(16'($urandom_range(NODE_COUNT - 1)), 2, 6, 6, 0);
        send_node(16'(NODE_COUNT), 1, 9, 9, 0);
        send_node(16'hFFFF, 1, 1, 2, 0);
    endtask

    task automatic test_random_nodes(input int goal);
        int r;
        while (items_sent < goal)
        begin
            r = $urandom_range(99);
            if (r < 5)
                send_node(pick_node(), 1, 200, 255, $urandom_range(40, 11));
            else if (r < 20)
                send_node(pick_node(), $urandom_range(3, 1), 0, 4,
                          $urandom_range(30, 1));
            else
                send_node(pick_node(), $urandom_range(3, 1), 0, 4, 0);
        end
    endtask

    task automatic test_steady_stream(input int goal);
        steady = 1'b1;
        test_random_nodes(goal);
        steady = 1'b0;
    endtask

    task automatic test_noise(input int count);
        for (int i = 0; i < count; i++)
            send_byte(16'($urandom), 8'($urandom),
                      (i == count - 1) || ($urandom_range(15) == 0));
    endtask

    initial
    begin
        items_sent     = 0;
        records_seen   = 0;
        models_dropped = 0;
        nodes_closed   = 0;
        mismatches     = 0;
        steady         = 1'b0;
        reset_predictor();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_extremes();
        test_cut_short();
        test_table_full();
        test_random_nodes(items_sent + 700);
        test_steady_stream(items_sent + 300);
        test_noise(150);

        in_valid <= 1'b0;
        while (expected_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input bytes, %0d streams closed, %0d records checked",
                 items_sent, nodes_closed, records_seen);
        $display("%0d records flagged dropped, %0d mismatches", models_dropped,
                 mismatches);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
